// ----- hw/rtl/imop_pkg.sv -----
package imop_pkg;

    // Coordinate width, fixed by the port fields.
    localparam int COORD_W            = 32;
    localparam int IMOP_MAX_INTERVALS = 256;

    // Status codes of the result word.
    localparam logic [1:0] ST_OK    = 2'd0;   // clean set
    localparam logic [1:0] ST_ORDER = 2'd1;   // an interval had left above right
    localparam logic [1:0] ST_FULL  = 2'd2;   // more intervals than the store holds

    // One sweep event. The key is the coordinate with its sign bit inverted,
    // so that an unsigned compare of the whole struct orders events by
    // coordinate and then start (0) before end (1).
    typedef struct packed {
        logic [COORD_W-1:0] key;
        logic               is_end;
    } imop_ev_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic     ins;   // insert ev at its sorted place
        logic     shl;   // shift the whole row one cell towards the head
        imop_ev_t ev;
    } imop_ctrl_t;

endpackage

// ----- hw/rtl/interval_max_overlap_point.sv -----
// Sweep-line maximum overlap of closed intervals. Each input word carries one
// interval (s_tdata = left, right) and s_tlast marks the final interval of a
// set. Every stored interval becomes a start and an end event, inserted into a
// row of 2*MAX_INTERVALS compare-and-shift cells that keeps the events sorted
// by coordinate, start before end on equal coordinates. Loading takes one
// cell-row insertion per event; a rejected interval is not inserted. After
// the last interval its end event (when stored) is inserted; then the row
// drains through its head one event per cycle into a running counter and the
// result is registered; s_tready is low throughout. The one result word holds
// the best point (latest start reaching the maximum count), that count and a
// status: 1 if some interval had left above right (not stored), 2 if more
// than MAX_INTERVALS intervals arrived (extra ones dropped); the first error
// of a set is kept and forces point and count to zero, as does an empty set.
// The result waits in an output register, so loading of the next set may
// start while it is still pending; the next set then holds at the end of its
// sweep until that word has gone. The block is cleared after each set.
module interval_max_overlap_point
    import imop_pkg::*;
#(
    parameter int MAX_INTERVALS = IMOP_MAX_INTERVALS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] left_end, [63:32] right_end
    input  logic        s_tlast,   // last_interval
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [31:0] best_point, [40:32] max_count,
                                   // [42:41] status, [47:43] zero
);

    localparam int DEPTH = 2 * MAX_INTERVALS;
    localparam int LD_W  = $clog2(MAX_INTERVALS + 1);
    localparam int EXT_W = (LD_W > 9) ? LD_W : 9;

    typedef enum logic [1:0] {
        S_IDLE,
        S_END,
        S_SWEEP
    } state_t;

    state_t             state_reg;
    logic [LD_W-1:0]    loaded_reg;
    logic [1:0]         err_reg;
    logic               last_reg;
    logic [COORD_W-1:0] pend_reg;     // right key waiting for insertion
    logic [LD_W-1:0]    run_reg;
    logic [LD_W-1:0]    best_cnt_reg;
    logic [COORD_W-1:0] best_pt_reg;

    logic               m_valid_reg;
    logic [COORD_W-1:0] out_pt_reg;
    logic [8:0]         out_cnt_reg;
    logic [1:0]         out_st_reg;

    imop_ctrl_t         ctrl;
    imop_ev_t           head_ev;
    logic               head_valid;

    logic               acc;
    logic               bad_order;
    logic               full;
    logic [COORD_W-1:0] left_key;
    logic [COORD_W-1:0] right_key;
    logic [LD_W-1:0]    run_inc;
    logic               sweep_done;
    logic [EXT_W-1:0]   best_ext;

    assign s_tready  = (state_reg == S_IDLE);
    assign acc       = s_tvalid && s_tready;
    assign bad_order = $signed(s_tdata[31:0]) > $signed(s_tdata[63:32]);
    assign full      = loaded_reg >= LD_W'(MAX_INTERVALS);
    assign left_key  = {~s_tdata[31], s_tdata[30:0]};
    assign right_key = {~s_tdata[63], s_tdata[62:32]};
    assign run_inc   = run_reg + LD_W'(1);
    // chain is sorted and contiguous, so an empty head means the sweep is over
    assign sweep_done = (state_reg == S_SWEEP) && !head_valid
                        && (!m_valid_reg || m_tready);
    assign best_ext  = EXT_W'(best_cnt_reg);

    // start event straight from the bus, end event from pend_reg in S_END
    always_comb begin
        ctrl.ins = 1'b0;
        ctrl.shl = 1'b0;
        ctrl.ev  = '{key: left_key, is_end: 1'b0};
        case (state_reg)
            S_IDLE: begin
                ctrl.ins = acc && !bad_order && !full;
            end
            S_END: begin
                ctrl.ins = 1'b1;
                ctrl.ev  = '{key: pend_reg, is_end: 1'b1};
            end
            S_SWEEP: begin
                ctrl.shl = head_valid;
            end
            default: begin
                ctrl.ins = 1'b0;
            end
        endcase
    end

    imop_chain #(
        .DEPTH (DEPTH)
    ) u_chain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .head_ev    (head_ev),
        .head_valid (head_valid)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            loaded_reg   <= '0;
            err_reg      <= ST_OK;
            last_reg     <= 1'b0;
            run_reg      <= '0;
            best_cnt_reg <= '0;
            best_pt_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            // a new result loaded in the same cycle keeps the flag set
            if (m_valid_reg && m_tready && !sweep_done) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (acc) begin
                        last_reg <= s_tlast;
                        pend_reg <= right_key;
                        if (bad_order) begin
                            if (err_reg == ST_OK) begin
                                err_reg <= ST_ORDER;
                            end
                            state_reg <= s_tlast ? S_SWEEP : S_IDLE;
                        end else if (full) begin
                            if (err_reg == ST_OK) begin
                                err_reg <= ST_FULL;
                            end
                            state_reg <= s_tlast ? S_SWEEP : S_IDLE;
                        end else begin
                            loaded_reg <= loaded_reg + LD_W'(1);
                            state_reg  <= S_END;
                        end
                    end
                end
                S_END: begin
                    state_reg <= last_reg ? S_SWEEP : S_IDLE;
                end
                S_SWEEP: begin
                    if (head_valid) begin
                        if (!head_ev.is_end) begin
                            run_reg <= run_inc;
                            if (run_inc >= best_cnt_reg) begin
                                best_cnt_reg <= run_inc;
                                best_pt_reg  <= {~head_ev.key[COORD_W-1],
                                                 head_ev.key[COORD_W-2:0]};
                            end
                        end else if (run_reg != '0) begin
                            run_reg <= run_reg - LD_W'(1);
                        end
                    end else if (sweep_done) begin
                        m_valid_reg <= 1'b1;
                        if (err_reg != ST_OK || loaded_reg == '0) begin
                            out_pt_reg  <= '0;
                            out_cnt_reg <= '0;
                        end else begin
                            out_pt_reg  <= best_pt_reg;
                            out_cnt_reg <= best_ext[8:0];
                        end
                        out_st_reg   <= err_reg;
                        loaded_reg   <= '0;
                        err_reg      <= ST_OK;
                        run_reg      <= '0;
                        best_cnt_reg <= '0;
                        best_pt_reg  <= '0;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, out_st_reg, out_cnt_reg, out_pt_reg};

`ifndef SYNTHESIS
    // store never holds more intervals than it has cells for
    a_loaded_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        loaded_reg <= LD_W'(MAX_INTERVALS))
        else $error("interval count beyond capacity");

    // while the block waits for input, the row holds events exactly when intervals are loaded
    a_head_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> (head_valid == (loaded_reg != '0)))
        else $error("event row and interval count disagree");

    // running count never exceeds the best count seen so far
    a_best_ge_run: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg <= best_cnt_reg)
        else $error("running count above best count");

    // a set with an error reports point and count zero
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_st_reg != ST_OK) |-> (out_cnt_reg == '0 && out_pt_reg == '0))
        else $error("error result carries a count");
`endif

endmodule

// ----- hw/rtl/imop_cell.sv -----
module imop_cell
    import imop_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  imop_ctrl_t ctrl,
    input  imop_ev_t   prev_ev,
    input  logic       prev_valid,
    input  logic       prev_gt,
    input  imop_ev_t   nxt_ev,
    input  logic       nxt_valid,
    output imop_ev_t   ev,
    output logic       valid,
    output logic       gt
);

    imop_ev_t ev_reg, ev_next;
    logic     valid_reg, valid_next;

    // empty cell counts as +infinity
    assign gt    = !valid_reg || (ctrl.ev < ev_reg);
    assign ev    = ev_reg;
    assign valid = valid_reg;

    always_comb begin
        ev_next    = ev_reg;
        valid_next = valid_reg;
        if (ctrl.ins) begin
            if (gt) begin
                if (prev_gt) begin
                    ev_next    = prev_ev;
                    valid_next = prev_valid;
                end else begin
                    ev_next    = ctrl.ev;
                    valid_next = 1'b1;
                end
            end
        end else if (ctrl.shl) begin
            ev_next    = nxt_ev;
            valid_next = nxt_valid;
        end
    end

    always_ff @(posedge aclk) begin
        ev_reg <= ev_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

endmodule

// ----- hw/rtl/imop_chain.sv -----
module imop_chain
    import imop_pkg::*;
#(
    parameter int DEPTH = 2 * IMOP_MAX_INTERVALS
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  imop_ctrl_t ctrl,
    output imop_ev_t   head_ev,
    output logic       head_valid
);

    imop_ev_t ev_w    [DEPTH];
    logic     valid_w [DEPTH];
    logic     gt_w    [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        imop_ev_t p_ev, n_ev;
        logic     p_valid, p_gt, n_valid;

        if (i == 0) begin : g_first
            assign p_ev    = '0;
            assign p_valid = 1'b0;
            assign p_gt    = 1'b0;
        end else begin : g_mid
            assign p_ev    = ev_w[i-1];
            assign p_valid = valid_w[i-1];
            assign p_gt    = gt_w[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign n_ev    = '0;
            assign n_valid = 1'b0;
        end else begin : g_inner
            assign n_ev    = ev_w[i+1];
            assign n_valid = valid_w[i+1];
        end

        imop_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .prev_ev    (p_ev),
            .prev_valid (p_valid),
            .prev_gt    (p_gt),
            .nxt_ev     (n_ev),
            .nxt_valid  (n_valid),
            .ev         (ev_w[i]),
            .valid      (valid_w[i]),
            .gt         (gt_w[i])
        );
    end

    assign head_ev    = ev_w[0];
    assign head_valid = valid_w[0];

endmodule
